FILE: src/turtle_command_interpreter_unit_assert.svh
// assertion macros for the turtle command interpreter
// both expect i_clk and i_rst_n in the scope of use
`ifndef TURTLE_COMMAND_INTERPRETER_UNIT_ASSERT_SVH
`define TURTLE_COMMAND_INTERPRETER_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define TCI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("turtle interpreter check failed");

// consequent checked in the following cycle
`define TCI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("turtle interpreter check failed");

`endif

FILE: src/tci_pkg.sv
package tci_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int RUN_BITS_DEF    = 16;

    localparam int COORD_W = 31;
    localparam int POS_W   = 32;
    localparam int SCALE_W = 24;
    localparam int HEAD_W  = 5;
    localparam int SINE_W  = 17;
    localparam int IDX_W3  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int KIND_W  = 2;

    // shared multiplier geometry
    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;
    localparam int MHI_W  = 16;
    localparam int SUM_W  = 65;
    localparam int FRAC_W = 16;
    localparam int SAT_W  = 50;
    localparam int ROUND_HALF = 32768;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
    localparam logic [HEAD_W-1:0]  HEAD_LAST   = 5'd23;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SCALE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_MOVE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    localparam logic [7:0] CH_DRAW  = 8'h64;
    localparam logic [7:0] CH_MOVE  = 8'h75;
    localparam logic [7:0] CH_HOME  = 8'h72;
    localparam logic [7:0] CH_ORIG  = 8'h6f;
    localparam logic [7:0] CH_PUSH  = 8'h5b;
    localparam logic [7:0] CH_POP   = 8'h5d;
    localparam logic [7:0] CH_LEFT  = 8'h3c;
    localparam logic [7:0] CH_RIGHT = 8'h3e;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    typedef struct packed {
        logic                      start;
        logic [MUL_W-1:0]          count;
        logic [SCALE_W-1:0]        scale;
        logic [SINE_W-1:0]         sine;
        logic                      neg;
        logic signed [POS_W-1:0]   base;
    } t_axis_req;

    typedef struct packed {
        logic                      busy;
        logic                      done;
        logic signed [POS_W-1:0]   value;
    } t_axis_rsp;

    typedef struct packed {
        logic [IDX_W3-1:0] ix;
        logic [IDX_W3-1:0] iy;
        logic              nx;
        logic              ny;
    } t_dir;

    // sine of 0..90 degrees in 15 degree steps, Q.16
    function automatic logic [SINE_W-1:0] sine_q16(input logic [IDX_W3-1:0] idx);
        logic [SINE_W-1:0] v;
        case (idx)
            3'd0:    v = 17'd0;
            3'd1:    v = 17'd16962;
            3'd2:    v = 17'd32768;
            3'd3:    v = 17'd46341;
            3'd4:    v = 17'd56756;
            3'd5:    v = 17'd63303;
            3'd6:    v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // quadrant split of the heading into table indexes and signs
    function automatic t_dir heading_dir(input logic [HEAD_W-1:0] h);
        t_dir d;
        if (h < 5'd7) begin
            d.ix = h[IDX_W3-1:0];
            d.iy = IDX_W3'(5'd6 - h);
            d.nx = 1'b1;
            d.ny = 1'b1;
        end else if (h < 5'd13) begin
            d.ix = IDX_W3'(5'd12 - h);
            d.iy = IDX_W3'(h - 5'd6);
            d.nx = 1'b1;
            d.ny = 1'b0;
        end else if (h < 5'd19) begin
            d.ix = IDX_W3'(h - 5'd12);
            d.iy = IDX_W3'(5'd18 - h);
            d.nx = 1'b0;
            d.ny = 1'b0;
        end else begin
            d.ix = IDX_W3'(5'd24 - h);
            d.iy = IDX_W3'(h - 5'd18);
            d.nx = 1'b0;
            d.ny = 1'b1;
        end
        return d;
    endfunction

endpackage

FILE: src/tci_if.sv
interface tci_cmd_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] char_code;

    modport source (output valid, output op, output char_code, input ready);
    modport sink   (input valid, input op, input char_code, output ready);
endinterface

interface tci_res_if;
    logic                                  valid;
    logic                                  ready;
    logic [tci_pkg::KIND_W-1:0]            kind;
    logic signed [tci_pkg::POS_W-1:0]      pos_x;
    logic signed [tci_pkg::POS_W-1:0]      pos_y;
    logic                                  last;

    modport source (output valid, output kind, output pos_x, output pos_y, output last,
                    input ready);
    modport sink   (input valid, input kind, input pos_x, input pos_y, input last,
                    output ready);
endinterface

interface tci_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tci_pkg::CFG_IDX_W-1:0]     index;
    logic [tci_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/tci_axis.sv
module tci_axis (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tci_pkg::t_axis_req  i_req,
    output tci_pkg::t_axis_rsp  o_rsp
);

    localparam int MUL_W  = tci_pkg::MUL_W;
    localparam int PROD_W = tci_pkg::PROD_W;
    localparam int MHI_W  = tci_pkg::MHI_W;
    localparam int SUM_W  = tci_pkg::SUM_W;
    localparam int FRAC_W = tci_pkg::FRAC_W;
    localparam int SAT_W  = tci_pkg::SAT_W;
    localparam int POS_W  = tci_pkg::POS_W;
    localparam logic signed [SAT_W-1:0] HI_LIM = SAT_W'(2**(POS_W-1) - 1);
    localparam logic signed [SAT_W-1:0] LO_LIM = ~HI_LIM;

    typedef enum logic [2:0] {
        A_IDLE, A_P1, A_P2, A_P3, A_P4, A_P5
    } t_astate;

    t_astate                        r_state;
    logic [MUL_W-1:0]               r_count;
    logic [tci_pkg::SCALE_W-1:0]    r_scale;
    logic [tci_pkg::SINE_W-1:0]     r_sine;
    logic                           r_neg;
    logic signed [POS_W-1:0]        r_base;
    logic [PROD_W-1:0]              r_prod;
    logic [MHI_W-1:0]               r_mhi;
    logic [PROD_W-1:0]              r_lo;
    logic [SUM_W-1:0]               r_sum;

    logic [MUL_W-1:0]               mul_a;
    logic [MUL_W-1:0]               mul_b;
    logic signed [SAT_W-1:0]        sat_base;
    logic signed [SAT_W-1:0]        sat_mag;
    logic signed [SAT_W-1:0]        sat_sum;
    logic signed [POS_W-1:0]        sat_val;

    // one multiplier: scale*sine, then count times the low and high halves
    always_comb begin
        case (r_state)
            A_P1: begin
                mul_a = r_scale;
                mul_b = MUL_W'(r_sine);
            end
            A_P2: begin
                mul_a = r_count;
                mul_b = r_prod[MUL_W-1:0];
            end
            A_P3: begin
                mul_a = r_count;
                mul_b = MUL_W'(r_mhi);
            end
            default: begin
                mul_a = r_count;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        sat_base = {{(SAT_W-POS_W){r_base[POS_W-1]}}, r_base};
        sat_mag  = $signed({1'b0, r_sum[SUM_W-1:FRAC_W]});
        sat_sum  = r_neg ? (sat_base - sat_mag) : (sat_base + sat_mag);
        if (sat_sum > HI_LIM) begin
            sat_val = HI_LIM[POS_W-1:0];
        end else if (sat_sum < LO_LIM) begin
            sat_val = LO_LIM[POS_W-1:0];
        end else begin
            sat_val = sat_sum[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_prod <= mul_a * mul_b;
            case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_count <= i_req.count;
                        r_scale <= i_req.scale;
                        r_sine  <= i_req.sine;
                        r_neg   <= i_req.neg;
                        r_base  <= i_req.base;
                        r_state <= A_P1;
                    end
                end
                A_P1: r_state <= A_P2;
                A_P2: begin
                    r_mhi   <= r_prod[MUL_W+MHI_W-1:MUL_W];
                    r_state <= A_P3;
                end
                A_P3: begin
                    r_lo    <= r_prod;
                    r_state <= A_P4;
                end
                A_P4: begin
                    r_sum <= {{(SUM_W-PROD_W){1'b0}}, r_lo}
                           + ({{(SUM_W-PROD_W){1'b0}}, r_prod} << MUL_W)
                           + SUM_W'(tci_pkg::ROUND_HALF);
                    r_state <= A_P5;
                end
                A_P5: r_state <= A_IDLE;
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_rsp.busy  = (r_state != A_IDLE);
    assign o_rsp.done  = (r_state == A_P5);
    assign o_rsp.value = sat_val;

endmodule

FILE: src/turtle_command_interpreter_unit.sv
// turtle command interpreter: one byte per beat, ready low until the item is done
// a byte that only extends a run or is ignored is taken in idle; any other byte
// goes through the action state, then the emit state for home, origin and push, and
// the stack read and emit states for pop; a pending run flush first makes two passes
// (x then y) through the shared 24x24 multiplier unit and loads the result register
// reset (i_rst_n low at a clock edge) clears registers; emits wait on o_res.ready
`include "turtle_command_interpreter_unit_assert.svh"

module turtle_command_interpreter_unit #(
    parameter int STACK_DEPTH = tci_pkg::STACK_DEPTH_DEF,
    parameter int RUN_BITS    = tci_pkg::RUN_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tci_cmd_if.sink   i_cmd,
    tci_cfg_if.sink   i_cfg,
    tci_res_if.source o_res
);

    localparam int IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int POS_W  = tci_pkg::POS_W;
    localparam int HEAD_W = tci_pkg::HEAD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_FX, S_FXW, S_FY, S_FYW, S_FEMIT, S_ACT, S_POP, S_AEMIT
    } t_state;

    typedef enum logic [2:0] {
        ACT_NONE, ACT_HOME, ACT_ORIGIN, ACT_PUSH, ACT_POP, ACT_LEFT, ACT_RIGHT
    } t_act;

    t_state                          r_state;
    t_act                            r_act;
    logic [tci_pkg::COORD_W-1:0]     r_org_x;
    logic [tci_pkg::COORD_W-1:0]     r_org_y;
    logic [tci_pkg::SCALE_W-1:0]     r_scale;
    logic signed [POS_W-1:0]         r_cur_x;
    logic signed [POS_W-1:0]         r_cur_y;
    logic [HEAD_W-1:0]               r_heading;
    logic [RUN_BITS-1:0]             r_draw;
    logic [RUN_BITS-1:0]             r_move;
    logic [RUN_BITS-1:0]             r_cnt;
    logic [tci_pkg::KIND_W-1:0]      r_fkind;
    logic [tci_pkg::KIND_W-1:0]      r_ekind;
    logic [LVL_W-1:0]                r_level;
    logic                            r_halted;

    logic                            r_ov;
    logic [tci_pkg::KIND_W-1:0]      r_o_kind;
    logic signed [POS_W-1:0]         r_o_x;
    logic signed [POS_W-1:0]         r_o_y;
    logic                            r_o_last;

    logic [2*POS_W-1:0]              r_stack_xy [STACK_DEPTH];
    logic [HEAD_W-1:0]               r_stack_hd [STACK_DEPTH];
    logic [2*POS_W-1:0]              r_rd_xy;
    logic [HEAD_W-1:0]               r_rd_hd;

    tci_pkg::t_axis_req              axis_req;
    tci_pkg::t_axis_rsp              axis_rsp;
    tci_pkg::t_dir                   dir;
    t_act                            dec_act;
    logic                            cmd_take;
    logic                            cfg_take;
    logic                            slot_free;
    logic                            res_load;
    logic                            has_run;
    logic                            stack_full;
    logic                            act_silent;
    logic                            mem_we;
    logic                            mem_re;
    logic [IDX_W-1:0]                mem_addr;

    assign cmd_take   = i_cmd.valid && i_cmd.ready;
    assign cfg_take   = i_cfg.valid && i_cfg.ready;
    assign slot_free  = !r_ov || o_res.ready;
    assign res_load   = ((r_state == S_FEMIT) || (r_state == S_AEMIT)) && slot_free;
    assign has_run    = (r_draw != '0) || (r_move != '0);
    assign stack_full = (r_level >= LVL_W'(STACK_DEPTH));
    assign act_silent = (r_act == ACT_NONE) || (r_act == ACT_LEFT) || (r_act == ACT_RIGHT);
    assign dir        = tci_pkg::heading_dir(r_heading);

    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = (r_state == S_IDLE);

    assign o_res.valid = r_ov;
    assign o_res.kind  = r_o_kind;
    assign o_res.pos_x = r_o_x;
    assign o_res.pos_y = r_o_y;
    assign o_res.last  = r_o_last;

    always_comb begin
        case (i_cmd.char_code)
            tci_pkg::CH_HOME:  dec_act = ACT_HOME;
            tci_pkg::CH_ORIG:  dec_act = ACT_ORIGIN;
            tci_pkg::CH_PUSH:  dec_act = ACT_PUSH;
            tci_pkg::CH_POP:   dec_act = ACT_POP;
            tci_pkg::CH_LEFT:  dec_act = ACT_LEFT;
            tci_pkg::CH_RIGHT: dec_act = ACT_RIGHT;
            default:           dec_act = ACT_NONE;
        endcase
    end

    // x pass in S_FX, y pass in S_FY
    always_comb begin
        axis_req.start = (r_state == S_FX) || (r_state == S_FY);
        axis_req.count = tci_pkg::MUL_W'(r_cnt);
        axis_req.scale = r_scale;
        if (r_state == S_FY) begin
            axis_req.sine = tci_pkg::sine_q16(dir.iy);
            axis_req.neg  = dir.ny;
            axis_req.base = r_cur_y;
        end else begin
            axis_req.sine = tci_pkg::sine_q16(dir.ix);
            axis_req.neg  = dir.nx;
            axis_req.base = r_cur_x;
        end
    end

    tci_axis u_axis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (axis_req),
        .o_rsp   (axis_rsp)
    );

    assign mem_we   = (r_state == S_ACT) && (r_act == ACT_PUSH) && !stack_full;
    assign mem_re   = (r_state == S_ACT) && (r_act == ACT_POP) && (r_level != '0);
    assign mem_addr = (r_act == ACT_POP) ? IDX_W'(r_level - LVL_W'(1))
                                         : IDX_W'(r_level);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack_xy[mem_addr] <= {r_cur_x, r_cur_y};
            r_stack_hd[mem_addr] <= r_heading;
        end
        if (mem_re) begin
            r_rd_xy <= r_stack_xy[mem_addr];
            r_rd_hd <= r_stack_hd[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_act      <= ACT_NONE;
            r_org_x    <= '0;
            r_org_y    <= '0;
            r_scale    <= tci_pkg::SCALE_RESET;
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_heading  <= '0;
            r_draw     <= '0;
            r_move     <= '0;
            r_level    <= '0;
            r_halted   <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready && !res_load) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (cmd_take && !r_halted) begin
                        r_act <= i_cmd.op ? ACT_NONE : dec_act;
                        if (i_cmd.op) begin
                            if (has_run) begin
                                r_cnt   <= (r_draw != '0) ? r_draw : r_move;
                                r_fkind <= (r_draw != '0) ? tci_pkg::KIND_LINE
                                                          : tci_pkg::KIND_MOVE;
                                r_draw  <= '0;
                                r_move  <= '0;
                                r_state <= S_FX;
                            end
                        end else begin
                            case (i_cmd.char_code)
                                tci_pkg::CH_DRAW: begin
                                    if (r_move != '0) begin
                                        r_cnt   <= r_move;
                                        r_fkind <= tci_pkg::KIND_MOVE;
                                        r_move  <= '0;
                                        r_state <= S_FX;
                                    end
                                    if (r_draw != '1) begin
                                        r_draw <= r_draw + RUN_BITS'(1);
                                    end
                                end
                                tci_pkg::CH_MOVE: begin
                                    if (r_draw != '0) begin
                                        r_cnt   <= r_draw;
                                        r_fkind <= tci_pkg::KIND_LINE;
                                        r_draw  <= '0;
                                        r_state <= S_FX;
                                    end
                                    if (r_move != '1) begin
                                        r_move <= r_move + RUN_BITS'(1);
                                    end
                                end
                                default: begin
                                    if (!(i_cmd.char_code inside {tci_pkg::CH_SPACE,
                                            [tci_pkg::CH_TAB:tci_pkg::CH_CR]})) begin
                                        if (has_run) begin
                                            r_cnt   <= (r_draw != '0) ? r_draw : r_move;
                                            r_fkind <= (r_draw != '0) ? tci_pkg::KIND_LINE
                                                                      : tci_pkg::KIND_MOVE;
                                            r_draw  <= '0;
                                            r_move  <= '0;
                                            r_state <= S_FX;
                                        end else begin
                                            r_state <= S_ACT;
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_FX: r_state <= S_FXW;
                S_FXW: begin
                    if (axis_rsp.done) begin
                        r_cur_x <= axis_rsp.value;
                        r_state <= S_FY;
                    end
                end
                S_FY: r_state <= S_FYW;
                S_FYW: begin
                    if (axis_rsp.done) begin
                        r_cur_y <= axis_rsp.value;
                        r_state <= S_FEMIT;
                    end
                end
                S_FEMIT: begin
                    if (slot_free) begin
                        r_ov     <= 1'b1;
                        r_o_kind <= r_fkind;
                        r_o_x    <= r_cur_x;
                        r_o_y    <= r_cur_y;
                        r_o_last <= act_silent;
                        r_state  <= S_ACT;
                    end
                end
                S_ACT: begin
                    case (r_act)
                        ACT_HOME: begin
                            r_heading <= '0;
                            r_cur_x   <= $signed({1'b0, r_org_x});
                            r_cur_y   <= $signed({1'b0, r_org_y});
                            r_ekind   <= tci_pkg::KIND_MOVE;
                            r_state   <= S_AEMIT;
                        end
                        ACT_ORIGIN: begin
                            r_cur_x <= $signed({1'b0, r_org_x});
                            r_cur_y <= $signed({1'b0, r_org_y});
                            r_ekind <= tci_pkg::KIND_MOVE;
                            r_state <= S_AEMIT;
                        end
                        ACT_PUSH: begin
                            if (stack_full) begin
                                r_halted <= 1'b1;
                                r_ekind  <= tci_pkg::KIND_ERR;
                            end else begin
                                r_level <= r_level + LVL_W'(1);
                                r_ekind <= tci_pkg::KIND_MOVE;
                            end
                            r_state <= S_AEMIT;
                        end
                        ACT_POP: begin
                            if (r_level == '0) begin
                                r_halted <= 1'b1;
                                r_ekind  <= tci_pkg::KIND_ERR;
                                r_state  <= S_AEMIT;
                            end else begin
                                r_level <= r_level - LVL_W'(1);
                                r_ekind <= tci_pkg::KIND_MOVE;
                                r_state <= S_POP;
                            end
                        end
                        ACT_LEFT: begin
                            r_heading <= (r_heading == tci_pkg::HEAD_LAST) ? '0
                                         : r_heading + HEAD_W'(1);
                            r_state   <= S_IDLE;
                        end
                        ACT_RIGHT: begin
                            r_heading <= (r_heading == '0) ? tci_pkg::HEAD_LAST
                                         : r_heading - HEAD_W'(1);
                            r_state   <= S_IDLE;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_POP: begin
                    // registered stack read lands here
                    r_cur_x   <= $signed(r_rd_xy[2*POS_W-1:POS_W]);
                    r_cur_y   <= $signed(r_rd_xy[POS_W-1:0]);
                    r_heading <= r_rd_hd;
                    r_state   <= S_AEMIT;
                end
                S_AEMIT: begin
                    if (slot_free) begin
                        r_ov     <= 1'b1;
                        r_o_kind <= r_ekind;
                        r_o_x    <= r_cur_x;
                        r_o_y    <= r_cur_y;
                        r_o_last <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (cfg_take) begin
                case (i_cfg.index)
                    tci_pkg::CFG_ORIGIN_X: begin
                        r_org_x <= i_cfg.data[tci_pkg::COORD_W-1:0];
                        r_cur_x <= $signed({1'b0, i_cfg.data[tci_pkg::COORD_W-1:0]});
                    end
                    tci_pkg::CFG_ORIGIN_Y: begin
                        r_org_y <= i_cfg.data[tci_pkg::COORD_W-1:0];
                        r_cur_y <= $signed({1'b0, i_cfg.data[tci_pkg::COORD_W-1:0]});
                    end
                    tci_pkg::CFG_STEP_SCALE: begin
                        r_scale <= i_cfg.data[tci_pkg::SCALE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // once halted and drained, nothing new appears on the output
    `TCI_ASSERT_NEXT(a_halt_silent, r_halted && !r_ov && r_state == S_IDLE, !r_ov)
    // a new byte is never taken while the shared unit is still working
    `TCI_ASSERT_NOW(a_ready_unit_idle, i_cmd.ready, !axis_rsp.busy)
    // a stack error is always the final beat and leaves the block halted
    `TCI_ASSERT_NOW(a_err_last, r_ov && r_o_kind == tci_pkg::KIND_ERR, r_o_last && r_halted)

endmodule
